>>> rtl/core/psls_pkg.sv
// Shared types, command codes and defaults for the per-source latency statistics block.
package psls_pkg;

  localparam int unsigned SOURCES_DEF = 16;
  localparam int unsigned DEVICES_DEF = 16;

  // Input command codes
  typedef enum logic [2:0] {
    CMD_MADE       = 3'd0,
    CMD_RECEIVED   = 3'd1,
    CMD_SERVED     = 3'd2,
    CMD_FAILED     = 3'd3,
    CMD_SRC_REPORT = 3'd4,
    CMD_DEV_REPORT = 3'd5,
    CMD_RSVD6      = 3'd6,
    CMD_RSVD7      = 3'd7
  } cmd_e;

  // Division job selects
  typedef enum logic [2:0] {
    DIV_RATIO = 3'd0,
    DIV_INSYS = 3'd1,
    DIV_WAIT  = 3'd2,
    DIV_SERV  = 3'd3,
    DIV_WSQ   = 3'd4,
    DIV_SSQ   = 3'd5,
    DIV_UTIL  = 3'd6,
    DIV_NONE  = 3'd7
  } div_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_WRITE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_VMUL,
    ST_VSUB,
    ST_LOAD,
    ST_OUT
  } state_e;

  // One source entry
  typedef struct packed {
    logic [31:0] gen;
    logic [31:0] fail;
    logic [31:0] srv;
    logic [63:0] insys;
    logic [63:0] wsum;
    logic [63:0] wsq;
    logic [63:0] ssum;
    logic [63:0] ssq;
  } src_row_t;

  // Controller to datapath
  typedef struct packed {
    logic     load_in;
    logic     rd_en;
    logic     mul_en;
    logic     mul_var;
    logic     wr_en;
    logic     div_start;
    logic     div_store;
    div_sel_e div_sel;
    logic     var_sel;
    logic     var_store;
    logic     out_load;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    cmd_e cmd;
    logic div_done;
  } dp_stat_t;

endpackage

>>> rtl/core/psls_div.sv
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
module psls_div import psls_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quotient_o
);

  logic        busy_q, busy_d, done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d, dsr_q, dsr_d;
  logic [63:0] quo_q, quo_d;
  logic [32:0] rem_sh, rem_sub;

  // one shift-subtract step
  always_comb begin
    rem_sh  = {rem_q, quo_q[63]};
    rem_sub = rem_sh - {1'b0, dsr_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dsr_d   = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dsr_q}) begin
        rem_d = rem_sub[31:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = rem_sh[31:0];
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> rtl/core/psls_dp.sv
// Datapath: input word register, statistics memories, squarer, divider and result registers.
module psls_dp import psls_pkg::*; #(
  parameter int unsigned SOURCES = SOURCES_DEF,
  parameter int unsigned DEVICES = DEVICES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  output dp_stat_t    stat_o,
  input  logic [2:0]  cmd_in_i,
  input  logic [4:0]  source_id_i,
  input  logic [3:0]  device_id_i,
  input  logic [31:0] created_time_i,
  input  logic [31:0] accepted_time_i,
  input  logic [31:0] finished_time_i,
  input  logic [31:0] now_time_i,
  output logic        report_kind_o,
  output logic [31:0] generated_count_o,
  output logic [16:0] failure_ratio_o,
  output logic [31:0] mean_in_system_o,
  output logic [31:0] mean_wait_o,
  output logic [31:0] mean_service_o,
  output logic [63:0] wait_variance_o,
  output logic [63:0] service_variance_o,
  output logic [16:0] device_utilization_o,
  output logic [1:0]  empty_flags_o
);

  localparam int unsigned SW = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam int unsigned DW = (DEVICES > 1) ? $clog2(DEVICES) : 1;
  localparam logic [16:0] Q16_ONE = 17'h10000;

  // latched input word
  cmd_e        cmd_q;
  logic [4:0]  sid_q;
  logic [3:0]  did_q;
  logic [31:0] cre_q, acc_q, fin_q, now_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cmd_q <= cmd_e'(cmd_in_i);
      sid_q <= source_id_i;
      did_q <= device_id_i;
      cre_q <= created_time_i;
      acc_q <= accepted_time_i;
      fin_q <= finished_time_i;
      now_q <= now_time_i;
    end
  end

  // address decode
  logic [8:0]    sid_ext;
  logic          src_ok, dev_ok;
  logic [SW-1:0] s_idx;
  logic [DW-1:0] d_idx;

  always_comb begin
    sid_ext = {4'd0, sid_q};
    src_ok  = (sid_ext != 9'd0) && (sid_ext <= 9'(SOURCES));
    dev_ok  = ({5'd0, did_q} < 9'(DEVICES));
    s_idx   = SW'(sid_ext - 9'd1);
    d_idx   = DW'({5'd0, did_q});
  end

  // statistics memories; entries not yet written read as zero
  src_row_t    row_mem [SOURCES];
  logic [63:0] busy_mem [DEVICES];
  logic [SOURCES-1:0] row_vld_q;
  logic [DEVICES-1:0] busy_vld_q;
  src_row_t    rd_row_raw_q, rd_row;
  logic [63:0] rd_busy_raw_q, rd_busy;
  logic        rd_row_ok_q, rd_busy_ok_q;
  src_row_t    new_row;
  logic [63:0] new_busy;
  logic        busy_wr;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_row_raw_q  <= row_mem[s_idx];
      rd_busy_raw_q <= busy_mem[d_idx];
      rd_row_ok_q   <= src_ok && row_vld_q[s_idx];
      rd_busy_ok_q  <= dev_ok && busy_vld_q[d_idx];
    end
    if (cmd_i.wr_en && src_ok) begin
      row_mem[s_idx] <= new_row;
    end
    if (busy_wr) begin
      busy_mem[d_idx] <= new_busy;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q  <= '0;
      busy_vld_q <= '0;
    end else begin
      if (cmd_i.wr_en && src_ok) row_vld_q[s_idx] <= 1'b1;
      if (busy_wr) busy_vld_q[d_idx] <= 1'b1;
    end
  end

  assign rd_row  = rd_row_ok_q ? rd_row_raw_q : '0;
  assign rd_busy = rd_busy_ok_q ? rd_busy_raw_q : '0;

  // time differences, modulo 2^32
  logic [31:0] diff_w, diff_s, diff_sys, diff_fail;
  assign diff_w    = acc_q - cre_q;
  assign diff_s    = fin_q - acc_q;
  assign diff_sys  = fin_q - cre_q;
  assign diff_fail = now_q - cre_q;

  // division results
  logic [63:0] q_ratio_q, q_insys_q, q_wait_q, q_serv_q, q_wsq_q, q_ssq_q;
  logic [63:0] var_w_q, var_s_q;

  // shared squarer
  logic [31:0] mul_a;
  logic [63:0] sq_q;

  always_comb begin
    if (cmd_i.mul_var) mul_a = cmd_i.var_sel ? q_serv_q[31:0] : q_wait_q[31:0];
    else if (cmd_q == CMD_RECEIVED) mul_a = diff_w;
    else mul_a = diff_s;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) sq_q <= {32'd0, mul_a} * {32'd0, mul_a};
  end

  // event updates
  always_comb begin
    new_row  = rd_row;
    new_busy = rd_busy + {32'd0, diff_s};
    busy_wr  = 1'b0;
    case (cmd_q)
      CMD_MADE: new_row.gen = rd_row.gen + 32'd1;
      CMD_RECEIVED: begin
        new_row.wsum = rd_row.wsum + {32'd0, diff_w};
        new_row.wsq  = rd_row.wsq + sq_q;
      end
      CMD_SERVED: begin
        new_row.srv   = rd_row.srv + 32'd1;
        new_row.ssum  = rd_row.ssum + {32'd0, diff_s};
        new_row.ssq   = rd_row.ssq + sq_q;
        new_row.insys = rd_row.insys + {32'd0, diff_sys};
        busy_wr       = cmd_i.wr_en && src_ok && dev_ok;
      end
      CMD_FAILED: begin
        new_row.fail  = rd_row.fail + 32'd1;
        new_row.insys = rd_row.insys + {32'd0, diff_fail};
      end
      default: new_row = rd_row;
    endcase
  end

  // divider operand select
  logic [63:0] div_num, div_q;
  logic [31:0] div_den;
  logic        div_done;

  always_comb begin
    div_num = '0;
    div_den = rd_row.srv;
    case (cmd_i.div_sel)
      DIV_RATIO: begin div_num = {16'd0, rd_row.fail, 16'd0}; div_den = rd_row.gen; end
      DIV_INSYS: begin div_num = rd_row.insys; div_den = rd_row.gen; end
      DIV_WAIT:  div_num = rd_row.wsum;
      DIV_SERV:  div_num = rd_row.ssum;
      DIV_WSQ:   div_num = rd_row.wsq;
      DIV_SSQ:   div_num = rd_row.ssq;
      DIV_UTIL:  begin div_num = {rd_busy[47:0], 16'd0}; div_den = now_q; end
      default:   div_num = '0;
    endcase
  end

  psls_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_store) begin
      case (cmd_i.div_sel)
        DIV_RATIO, DIV_UTIL: q_ratio_q <= div_q;
        DIV_INSYS: q_insys_q <= div_q;
        DIV_WAIT:  q_wait_q  <= div_q;
        DIV_SERV:  q_serv_q  <= div_q;
        DIV_WSQ:   q_wsq_q   <= div_q;
        DIV_SSQ:   q_ssq_q   <= div_q;
        default:   q_ratio_q <= q_ratio_q;
      endcase
    end
  end

  // variance: mean of squares minus square of mean, clamped at zero
  logic [63:0] var_q_sel, var_m_sel, var_res;
  always_comb begin
    var_q_sel = cmd_i.var_sel ? q_ssq_q : q_wsq_q;
    var_m_sel = cmd_i.var_sel ? q_serv_q : q_wait_q;
    if (var_m_sel[63:32] != 32'd0) var_res = '0;
    else if (var_q_sel >= sq_q) var_res = var_q_sel - sq_q;
    else var_res = '0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.var_store) begin
      if (cmd_i.var_sel) var_s_q <= var_res;
      else var_w_q <= var_res;
    end
  end

  // result word
  function automatic logic [31:0] sat32(input logic [63:0] v);
    sat32 = (v[63:32] != 32'd0) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  typedef struct packed {
    logic        kind;
    logic [31:0] gen;
    logic [16:0] ratio;
    logic [31:0] insys;
    logic [31:0] wmean;
    logic [31:0] smean;
    logic [63:0] wvar;
    logic [63:0] svar;
    logic [16:0] util;
    logic [1:0]  flags;
  } res_t;

  logic gen_zero, srv_zero, now_zero;
  assign gen_zero = (rd_row.gen == 32'd0);
  assign srv_zero = (rd_row.srv == 32'd0);
  assign now_zero = (now_q == 32'd0);

  res_t res_d, res_q;

  // unused fields of a report stay zero
  always_comb begin
    res_d = '0;
    if (cmd_q == CMD_DEV_REPORT) begin
      res_d.kind  = 1'b1;
      res_d.flags = {1'b0, now_zero};
      if (!now_zero) begin
        res_d.util = (rd_busy >= {32'd0, now_q}) ? Q16_ONE : q_ratio_q[16:0];
      end
    end else begin
      res_d.gen   = rd_row.gen;
      res_d.flags = {srv_zero, gen_zero};
      if (!gen_zero) begin
        res_d.ratio = (rd_row.fail >= rd_row.gen) ? Q16_ONE : q_ratio_q[16:0];
        res_d.insys = sat32(q_insys_q);
      end
      if (!srv_zero) begin
        res_d.wmean = sat32(q_wait_q);
        res_d.smean = sat32(q_serv_q);
        res_d.wvar  = var_w_q;
        res_d.svar  = var_s_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) res_q <= res_d;
  end

  assign report_kind_o        = res_q.kind;
  assign generated_count_o    = res_q.gen;
  assign failure_ratio_o      = res_q.ratio;
  assign mean_in_system_o     = res_q.insys;
  assign mean_wait_o          = res_q.wmean;
  assign mean_service_o       = res_q.smean;
  assign wait_variance_o      = res_q.wvar;
  assign service_variance_o   = res_q.svar;
  assign device_utilization_o = res_q.util;
  assign empty_flags_o        = res_q.flags;

  assign stat_o.cmd      = cmd_q;
  assign stat_o.div_done = div_done;

endmodule

>>> rtl/core/psls_ctrl.sv
// Controller: sequences read, square, write-back, divisions and result handoff.
module psls_ctrl import psls_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  state_e   state_q, state_d;
  div_sel_e sel_q, sel_d;
  logic     var_q, var_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sel_q   <= DIV_RATIO;
      var_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      var_q   <= var_d;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_d     = state_q;
    sel_d       = sel_q;
    var_d       = var_q;
    cmd_o       = '0;
    cmd_o.div_sel = sel_q;
    cmd_o.var_sel = var_q;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        case (stat_i.cmd)
          CMD_MADE, CMD_RECEIVED, CMD_SERVED, CMD_FAILED: state_d = ST_WRITE;
          CMD_SRC_REPORT: begin
            sel_d   = DIV_RATIO;
            state_d = ST_DIV_GO;
          end
          CMD_DEV_REPORT: begin
            sel_d   = DIV_UTIL;
            state_d = ST_DIV_GO;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_WRITE: begin
        cmd_o.wr_en = 1'b1;
        state_d = ST_IDLE;
      end
      ST_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (stat_i.div_done) begin
          cmd_o.div_store = 1'b1;
          if (sel_q == DIV_UTIL) begin
            state_d = ST_LOAD;
          end else if (sel_q == DIV_SSQ) begin
            var_d   = 1'b0;
            state_d = ST_VMUL;
          end else begin
            sel_d   = div_sel_e'(sel_q + 3'd1);
            state_d = ST_DIV_GO;
          end
        end
      end
      ST_VMUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_var = 1'b1;
        state_d = ST_VSUB;
      end
      ST_VSUB: begin
        cmd_o.var_store = 1'b1;
        if (var_q) begin
          state_d = ST_LOAD;
        end else begin
          var_d   = 1'b1;
          state_d = ST_VMUL;
        end
      end
      ST_LOAD: begin
        cmd_o.out_load = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/core/per_source_latency_statistics.sv
// Top level of the per-source latency statistics block.
// Keeps per-source request counts, time sums (wait, service, time in system), sums
// of squared wait and service times and per-device busy time, and answers source
// and device reports. One word is handled at a time. Event words (made, received,
// served, failed) go through a read of the source entry, squaring of the time
// difference and a write-back. A source report runs six passes of the shared
// one-bit-per-cycle divider plus two squaring steps for the variances; a device
// report runs one divider pass. A report word is held at the output until taken,
// and no new input word is taken meanwhile. Statistics start at zero after reset.
module per_source_latency_statistics import psls_pkg::*; #(
  parameter int unsigned SOURCES = SOURCES_DEF,
  parameter int unsigned DEVICES = DEVICES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  cmd_i,
  input  logic [4:0]  source_id_i,
  input  logic [3:0]  device_id_i,
  input  logic [31:0] created_time_i,
  input  logic [31:0] accepted_time_i,
  input  logic [31:0] finished_time_i,
  input  logic [31:0] now_time_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        report_kind_o,
  output logic [31:0] generated_count_o,
  output logic [16:0] failure_ratio_o,
  output logic [31:0] mean_in_system_o,
  output logic [31:0] mean_wait_o,
  output logic [31:0] mean_service_o,
  output logic [63:0] wait_variance_o,
  output logic [63:0] service_variance_o,
  output logic [16:0] device_utilization_o,
  output logic [1:0]  empty_flags_o
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  psls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  psls_dp #(
    .SOURCES (SOURCES),
    .DEVICES (DEVICES)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (dp_cmd),
    .stat_o               (dp_stat),
    .cmd_in_i             (cmd_i),
    .source_id_i          (source_id_i),
    .device_id_i          (device_id_i),
    .created_time_i       (created_time_i),
    .accepted_time_i      (accepted_time_i),
    .finished_time_i      (finished_time_i),
    .now_time_i           (now_time_i),
    .report_kind_o        (report_kind_o),
    .generated_count_o    (generated_count_o),
    .failure_ratio_o      (failure_ratio_o),
    .mean_in_system_o     (mean_in_system_o),
    .mean_wait_o          (mean_wait_o),
    .mean_service_o       (mean_service_o),
    .wait_variance_o      (wait_variance_o),
    .service_variance_o   (service_variance_o),
    .device_utilization_o (device_utilization_o),
    .empty_flags_o        (empty_flags_o)
  );

endmodule
